FILE: hw/rtl/bpf_pkg.sv
// shared types, widths and constants of the branch power flow block
package bpf_pkg;

  localparam int VOLT_W     = 18;
  localparam int ANG_W      = 25;
  localparam int DATA_W     = 32;
  localparam int TAP_W      = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int STATUS_W   = 2;

  // squared voltages, cordic datapath, rotated products, admittance terms
  localparam int SQ_W       = 21;
  localparam int CS_W       = 33;
  localparam int PC_W       = 23;
  localparam int COEF_W     = 41;
  localparam int WIDE_W     = 64;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_MAX       = 30;

  // angles in degrees, Q16.16
  localparam logic signed [ANG_W:0] ANG_FULL    = 26'sd23592960;
  localparam logic signed [ANG_W:0] ANG_HALF    = 26'sd11796480;
  localparam logic signed [ANG_W:0] ANG_QUARTER = 26'sd5898240;

  // 1/K of the cordic gain in Q2.30
  localparam logic signed [CS_W-1:0] CORDIC_START = 33'sd652032875;

  localparam logic [TAP_W-1:0] TAP_MIN = 31'd6554;
  localparam logic [TAP_W-1:0] TAP_ONE = 31'd65536;

  localparam logic [DATA_W-1:0] R_RESET   = 32'd0;
  localparam logic [DATA_W-1:0] X_RESET   = 32'd65536;
  localparam logic [DATA_W-1:0] G_RESET   = 32'd0;
  localparam logic [DATA_W-1:0] B_RESET   = 32'd0;
  localparam logic [TAP_W-1:0]  TAP_RESET = 31'd65536;

  // atan(2^-i) in degrees, Q8.24
  localparam logic signed [CS_W-1:0] ATAN_DEG [CORDIC_MAX] = '{
    33'sd754974720, 33'sd445687602, 33'sd235489089, 33'sd119537938,
    33'sd60000934,  33'sd30029717,  33'sd15018523,  33'sd7509720,
    33'sd3754917,   33'sd1877466,   33'sd938734,    33'sd469367,
    33'sd234684,    33'sd117342,    33'sd58671,     33'sd29335,
    33'sd14668,     33'sd7334,      33'sd3667,      33'sd1833,
    33'sd917,       33'sd458,       33'sd229,       33'sd115,
    33'sd57,        33'sd29,        33'sd14,        33'sd7,
    33'sd4,         33'sd2
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_R   = 3'd0,
    REG_X   = 3'd1,
    REG_G   = 3'd2,
    REG_B   = 3'd3,
    REG_TAP = 3'd4
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_SAT  = 2'd1,
    STAT_ZERO = 2'd2
  } status_t;

  // admittance terms of the pi model, Q16.16
  typedef struct packed {
    logic signed [COEF_W-1:0] y11r;
    logic signed [COEF_W-1:0] y11i;
    logic signed [COEF_W-1:0] y22r;
    logic signed [COEF_W-1:0] y22i;
    logic signed [COEF_W-1:0] y12r;
    logic signed [COEF_W-1:0] y12i;
    logic                     zero_z;
  } coef_t;

  // squared voltage terms carried alongside the cordic
  typedef struct packed {
    logic [SQ_W-1:0] vii;
    logic [SQ_W-1:0] vij;
    logic [SQ_W-1:0] vjj;
  } vpass_t;

endpackage

FILE: hw/rtl/bpf_div.sv
// iterative unsigned divider, one quotient bit per cycle
module bpf_div #(
  parameter int DIV_W = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] quo_r;
  logic [DIV_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;

  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      if (!diff[DIV_W]) begin
        rem_r <= diff[DIV_W-1:0];
      end else begin
        rem_r <= shifted[DIV_W-1:0];
      end
      quo_r <= {quo_r[DIV_W-2:0], ~diff[DIV_W]};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hw/rtl/bpf_coef.sv
// configuration registers and admittance term sequencer
module bpf_coef (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpf_pkg::DATA_W-1:0]     cfg_data,
  output bpf_pkg::coef_t                 coef,
  output logic                           coef_ok
);
  import bpf_pkg::*;

  typedef enum logic [2:0] {
    ST_SQR, ST_SQX, ST_CHK, ST_WAIT, ST_FIN, ST_RDY
  } state_t;

  typedef enum logic [2:0] {
    OP_GS, OP_BS, OP_GT, OP_BT, OP_GST, OP_BST, OP_GSTT, OP_BSTT
  } op_t;

  state_t state_r;
  op_t    op_r;
  logic   start_r;

  logic [DATA_W-1:0] r_r, x_r, g_r, b_r;
  logic [TAP_W-1:0]  tap_r;
  logic [WIDE_W-1:0] z_r;
  logic              zero_r;
  coef_t             coef_r;

  logic signed [COEF_W-1:0] gs_r, bs_r, gt_r, bt_r, gst_r, bst_r, gstt_r, bstt_r;

  logic [DATA_W-1:0]        r_mag, x_mag, g_mag, b_mag, mul_a;
  logic [WIDE_W-1:0]        sq;
  logic [TAP_W-1:0]         tap_eff;
  logic signed [COEF_W-1:0] src;
  logic [COEF_W-1:0]        src_mag;
  logic [WIDE_W-1:0]        dividend, divisor, quo;
  logic                     q_neg, div_done;
  logic signed [COEF_W-1:0] res;

  assign r_mag   = r_r[DATA_W-1] ? -r_r : r_r;
  assign x_mag   = x_r[DATA_W-1] ? -x_r : x_r;
  assign g_mag   = g_r[DATA_W-1] ? -g_r : g_r;
  assign b_mag   = b_r[DATA_W-1] ? -b_r : b_r;
  assign mul_a   = (state_r == ST_SQR) ? r_mag : x_mag;
  assign sq      = WIDE_W'(mul_a) * WIDE_W'(mul_a);
  assign tap_eff = (tap_r < TAP_MIN) ? TAP_ONE : tap_r;

  always_comb begin
    unique case (op_r)
      OP_GST:  src = gs_r;
      OP_BST:  src = bs_r;
      OP_GSTT: src = gst_r;
      default: src = bst_r;
    endcase
    src_mag = src[COEF_W-1] ? COEF_W'(-src) : COEF_W'(src);
    unique case (op_r)
      OP_GS: begin
        dividend = {r_mag, 32'd0} + (z_r >> 1);
        divisor  = z_r;
        q_neg    = r_r[DATA_W-1];
      end
      OP_BS: begin
        dividend = {x_mag, 32'd0} + (z_r >> 1);
        divisor  = z_r;
        q_neg    = ~x_r[DATA_W-1];
      end
      OP_GT: begin
        dividend = (WIDE_W'(g_mag) << 16) + WIDE_W'(tap_eff >> 1);
        divisor  = WIDE_W'(tap_eff);
        q_neg    = g_r[DATA_W-1];
      end
      OP_BT: begin
        dividend = (WIDE_W'(b_mag) << 16) + WIDE_W'(tap_eff >> 1);
        divisor  = WIDE_W'(tap_eff);
        q_neg    = b_r[DATA_W-1];
      end
      default: begin
        dividend = (WIDE_W'(src_mag) << 16) + WIDE_W'(tap_eff >> 1);
        divisor  = WIDE_W'(tap_eff);
        q_neg    = src[COEF_W-1];
      end
    endcase
    res = q_neg ? -$signed(quo[COEF_W-1:0]) : $signed(quo[COEF_W-1:0]);
  end

  bpf_div #(.DIV_W(WIDE_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SQR;
      op_r    <= OP_GS;
      start_r <= 1'b0;
      r_r     <= R_RESET;
      x_r     <= X_RESET;
      g_r     <= G_RESET;
      b_r     <= B_RESET;
      tap_r   <= TAP_RESET;
    end else if (cfg_valid) begin
      start_r <= 1'b0;
      state_r <= ST_SQR;
      unique case (cfg_index)
        REG_R:   r_r   <= cfg_data;
        REG_X:   x_r   <= cfg_data;
        REG_G:   g_r   <= cfg_data;
        REG_B:   b_r   <= cfg_data;
        REG_TAP: tap_r <= cfg_data[TAP_W-1:0];
        default: ;
      endcase
    end else begin
      start_r <= 1'b0;
      unique case (state_r)
        ST_SQR: begin
          z_r     <= sq;
          state_r <= ST_SQX;
        end
        ST_SQX: begin
          z_r     <= z_r + sq;
          state_r <= ST_CHK;
        end
        ST_CHK: begin
          zero_r <= (z_r == '0);
          if (z_r == '0) begin
            state_r <= ST_FIN;
          end else begin
            op_r    <= OP_GS;
            start_r <= 1'b1;
            state_r <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          // a done pulse in the start cycle belongs to an abandoned division
          if (div_done && !start_r) begin
            unique case (op_r)
              OP_GS:   gs_r   <= res;
              OP_BS:   bs_r   <= res;
              OP_GT:   gt_r   <= res;
              OP_BT:   bt_r   <= res;
              OP_GST:  gst_r  <= res;
              OP_BST:  bst_r  <= res;
              OP_GSTT: gstt_r <= res;
              default: bstt_r <= res;
            endcase
            if (op_r == OP_BSTT) begin
              state_r <= ST_FIN;
            end else begin
              op_r    <= op_t'(op_r + 1'b1);
              start_r <= 1'b1;
            end
          end
        end
        ST_FIN: begin
          coef_r.y11r   <= gs_r + gt_r;
          coef_r.y11i   <= bs_r + bt_r;
          coef_r.y22r   <= gstt_r + gt_r;
          coef_r.y22i   <= bstt_r + bt_r;
          coef_r.y12r   <= -gst_r;
          coef_r.y12i   <= -bst_r;
          coef_r.zero_z <= zero_r;
          state_r       <= ST_RDY;
        end
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign coef      = coef_r;
  assign coef_ok   = (state_r == ST_RDY);

endmodule

FILE: hw/rtl/bpf_cordic.sv
// pipelined cordic in degrees, one rotation per stage
module bpf_cordic #(
  parameter int STEPS = bpf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [bpf_pkg::CS_W-1:0]   in_z,
  input  logic                              in_neg,
  input  bpf_pkg::vpass_t                   in_pass,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bpf_pkg::CS_W-1:0]   out_x,
  output logic signed [bpf_pkg::CS_W-1:0]   out_y,
  output logic                              out_neg,
  output bpf_pkg::vpass_t                   out_pass
);
  import bpf_pkg::*;

  logic                   v_r   [STEPS];
  logic signed [CS_W-1:0] x_r   [STEPS];
  logic signed [CS_W-1:0] y_r   [STEPS];
  logic signed [CS_W-1:0] z_r   [STEPS];
  logic                   neg_r [STEPS];
  vpass_t                 pass_r[STEPS];
  logic                   rdy   [STEPS+1];

  assign rdy[STEPS] = out_ready;

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    logic                   v_in;
    logic signed [CS_W-1:0] x_in, y_in, z_in;
    logic                   neg_in;
    vpass_t                 p_in;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign x_in   = CORDIC_START;
      assign y_in   = '0;
      assign z_in   = in_z;
      assign neg_in = in_neg;
      assign p_in   = in_pass;
    end else begin : g_next
      assign v_in   = v_r[i-1];
      assign x_in   = x_r[i-1];
      assign y_in   = y_r[i-1];
      assign z_in   = z_r[i-1];
      assign neg_in = neg_r[i-1];
      assign p_in   = pass_r[i-1];
    end

    assign rdy[i] = !v_r[i] || rdy[i+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        if (!z_in[CS_W-1]) begin
          x_r[i] <= x_in - (y_in >>> i);
          y_r[i] <= y_in + (x_in >>> i);
          z_r[i] <= z_in - ATAN_DEG[i];
        end else begin
          x_r[i] <= x_in + (y_in >>> i);
          y_r[i] <= y_in - (x_in >>> i);
          z_r[i] <= z_in + ATAN_DEG[i];
        end
        neg_r[i]  <= neg_in;
        pass_r[i] <= p_in;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[STEPS-1];
  assign out_x     = x_r[STEPS-1];
  assign out_y     = y_r[STEPS-1];
  assign out_neg   = neg_r[STEPS-1];
  assign out_pass  = pass_r[STEPS-1];

endmodule

FILE: hw/rtl/bpf_power.sv
// power products, sums, rounding and saturation stages
module bpf_power (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [bpf_pkg::CS_W-1:0]   in_x,
  input  logic signed [bpf_pkg::CS_W-1:0]   in_y,
  input  logic                              in_neg,
  input  bpf_pkg::vpass_t                   in_pass,
  input  bpf_pkg::coef_t                    coef,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bpf_pkg::DATA_W-1:0] out_from_active,
  output logic signed [bpf_pkg::DATA_W-1:0] out_from_reactive,
  output logic signed [bpf_pkg::DATA_W-1:0] out_to_active,
  output logic signed [bpf_pkg::DATA_W-1:0] out_to_reactive,
  output logic signed [bpf_pkg::DATA_W-1:0] out_active_loss,
  output logic signed [bpf_pkg::DATA_W-1:0] out_reactive_loss,
  output logic [bpf_pkg::STATUS_W-1:0]      out_status
);
  import bpf_pkg::*;

  localparam int PW    = SQ_W + CS_W + 1;
  localparam int LO_W  = 20;
  localparam int PP_W  = PC_W + LO_W + 1;
  localparam int POW_W = 48;
  localparam int SUM_W = POW_W + 1;
  localparam int NPROD = 8;

  localparam logic signed [PW-1:0]     RND30 = PW'(1) << 29;
  localparam logic signed [WIDE_W-1:0] RND16 = WIDE_W'(1) << 15;
  localparam logic signed [SUM_W-1:0]  MAX32 = SUM_W'(2147483647);
  localparam logic signed [SUM_W-1:0]  MIN32 = -MAX32 - SUM_W'(1);

  function automatic logic [DATA_W:0] sat_fn(input logic signed [SUM_W-1:0] v);
    logic [DATA_W:0] r;
    if (v > MAX32) begin
      r = {1'b1, MAX32[DATA_W-1:0]};
    end else if (v < MIN32) begin
      r = {1'b1, MIN32[DATA_W-1:0]};
    end else begin
      r = {1'b0, v[DATA_W-1:0]};
    end
    return r;
  endfunction

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  // stage 1: rotated voltage product
  logic signed [CS_W-1:0] co, si;
  logic signed [PW-1:0]   pc_raw_r, ps_raw_r;
  logic [SQ_W-1:0]        vii1_r, vjj1_r;

  // stage 2: rounded to Q16.16
  logic signed [PC_W-1:0] pc_r, ps_r;
  logic [SQ_W-1:0]        vii2_r, vjj2_r;

  // stage 3: partial products
  logic signed [PC_W-1:0]   a_op [NPROD];
  logic signed [COEF_W-1:0] c_op [NPROD];
  logic signed [PP_W-1:0]   pl_r [NPROD];
  logic signed [PP_W-1:0]   ph_r [NPROD];

  // stage 4: whole products
  logic signed [WIDE_W-1:0] p_r [NPROD];

  // stage 5: rounded powers
  logic signed [WIDE_W-1:0] s_ip, s_iq, s_jp, s_jq;
  logic signed [POW_W-1:0]  ip_r, iq_r, jp_r, jq_r;

  // stage 6: losses, saturation and zeroing for a zero impedance
  logic signed [SUM_W-1:0] al, rl;
  logic [DATA_W:0]         f_ip, f_iq, f_jp, f_jq, f_al, f_rl;
  logic [DATA_W-1:0]       o_ip_r, o_iq_r, o_jp_r, o_jq_r, o_al_r, o_rl_r;
  status_t                 st_r;

  assign rdy6     = !v6_r || out_ready;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  assign co = in_neg ? -in_x : in_x;
  assign si = in_neg ? -in_y : in_y;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      pc_raw_r <= $signed({1'b0, in_pass.vij}) * co;
      ps_raw_r <= $signed({1'b0, in_pass.vij}) * si;
      vii1_r   <= in_pass.vii;
      vjj1_r   <= in_pass.vjj;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      pc_r   <= PC_W'((pc_raw_r + RND30) >>> 30);
      ps_r   <= PC_W'((ps_raw_r + RND30) >>> 30);
      vii2_r <= vii1_r;
      vjj2_r <= vjj1_r;
    end
  end

  always_comb begin
    a_op[0] = $signed(PC_W'(vii2_r)); c_op[0] = coef.y11r;
    a_op[1] = $signed(PC_W'(vii2_r)); c_op[1] = coef.y11i;
    a_op[2] = $signed(PC_W'(vjj2_r)); c_op[2] = coef.y22r;
    a_op[3] = $signed(PC_W'(vjj2_r)); c_op[3] = coef.y22i;
    a_op[4] = pc_r;                   c_op[4] = coef.y12r;
    a_op[5] = pc_r;                   c_op[5] = coef.y12i;
    a_op[6] = ps_r;                   c_op[6] = coef.y12r;
    a_op[7] = ps_r;                   c_op[7] = coef.y12i;
  end

  // coefficient split into a signed high part and an unsigned low part
  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int k = 0; k < NPROD; k++) begin
        pl_r[k] <= a_op[k] * $signed({1'b0, c_op[k][LO_W-1:0]});
        ph_r[k] <= a_op[k] * $signed(c_op[k][COEF_W-1:LO_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int k = 0; k < NPROD; k++) begin
        p_r[k] <= (WIDE_W'(ph_r[k]) <<< LO_W) + WIDE_W'(pl_r[k]);
      end
    end
  end

  assign s_ip =  p_r[0] + p_r[4] + p_r[7];
  assign s_iq = -p_r[1] + p_r[6] - p_r[5];
  assign s_jp =  p_r[2] + p_r[4] - p_r[7];
  assign s_jq = -p_r[3] - p_r[6] - p_r[5];

  always_ff @(posedge clk) begin
    if (rdy5) begin
      ip_r <= POW_W'((s_ip + RND16) >>> 16);
      iq_r <= POW_W'((s_iq + RND16) >>> 16);
      jp_r <= POW_W'((s_jp + RND16) >>> 16);
      jq_r <= POW_W'((s_jq + RND16) >>> 16);
    end
  end

  assign al   = SUM_W'(ip_r) + SUM_W'(jp_r);
  assign rl   = SUM_W'(iq_r) + SUM_W'(jq_r);
  assign f_ip = sat_fn(SUM_W'(ip_r));
  assign f_iq = sat_fn(SUM_W'(iq_r));
  assign f_jp = sat_fn(SUM_W'(jp_r));
  assign f_jq = sat_fn(SUM_W'(jq_r));
  assign f_al = sat_fn(al);
  assign f_rl = sat_fn(rl);

  always_ff @(posedge clk) begin
    if (rdy6) begin
      if (coef.zero_z) begin
        o_ip_r <= '0;
        o_iq_r <= '0;
        o_jp_r <= '0;
        o_jq_r <= '0;
        o_al_r <= '0;
        o_rl_r <= '0;
        st_r   <= STAT_ZERO;
      end else begin
        o_ip_r <= f_ip[DATA_W-1:0];
        o_iq_r <= f_iq[DATA_W-1:0];
        o_jp_r <= f_jp[DATA_W-1:0];
        o_jq_r <= f_jq[DATA_W-1:0];
        o_al_r <= f_al[DATA_W-1:0];
        o_rl_r <= f_rl[DATA_W-1:0];
        if (f_ip[DATA_W] || f_iq[DATA_W] || f_jp[DATA_W] || f_jq[DATA_W] ||
            f_al[DATA_W] || f_rl[DATA_W]) begin
          st_r <= STAT_SAT;
        end else begin
          st_r <= STAT_OK;
        end
      end
    end
  end

  assign out_valid         = v6_r;
  assign out_from_active   = $signed(o_ip_r);
  assign out_from_reactive = $signed(o_iq_r);
  assign out_to_active     = $signed(o_jp_r);
  assign out_to_reactive   = $signed(o_jq_r);
  assign out_active_loss   = $signed(o_al_r);
  assign out_reactive_loss = $signed(o_rl_r);
  assign out_status        = st_r;

endmodule

FILE: hw/rtl/branch_power_flow.sv
// top level of the pi model branch power flow pipeline
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_ready    from/to voltage, from/to angle
//  out      source     out_valid / out_ready  four end powers, two losses, status
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  one transfer per cycle on in and out unless out stalls or the sequencer runs;
//  stages are a front stage, one per cordic rotation and six product and sum stages
//  reset and every cfg transfer restart the admittance sequencer: two squares
//  then eight divisions unless the impedance is zero, with in_ready held low
//  a stall on out only fills empty stages, so in keeps taking transfers until
//  the pipeline is full; nothing is dropped or repeated
module branch_power_flow #(
  parameter int CORDIC_STEPS = bpf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // item input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bpf_pkg::VOLT_W-1:0]        in_from_voltage,
  input  logic [bpf_pkg::VOLT_W-1:0]        in_to_voltage,
  input  logic signed [bpf_pkg::ANG_W-1:0]  in_from_angle,
  input  logic signed [bpf_pkg::ANG_W-1:0]  in_to_angle,
  // result output
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bpf_pkg::DATA_W-1:0] out_from_active,
  output logic signed [bpf_pkg::DATA_W-1:0] out_from_reactive,
  output logic signed [bpf_pkg::DATA_W-1:0] out_to_active,
  output logic signed [bpf_pkg::DATA_W-1:0] out_to_reactive,
  output logic signed [bpf_pkg::DATA_W-1:0] out_active_loss,
  output logic signed [bpf_pkg::DATA_W-1:0] out_reactive_loss,
  output logic [bpf_pkg::STATUS_W-1:0]      out_status,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bpf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpf_pkg::DATA_W-1:0]        cfg_data
);
  import bpf_pkg::*;

  localparam int SQP_W = 2 * VOLT_W + 1;
  localparam logic [SQP_W-1:0] RND16 = SQP_W'(1) << 15;

  coef_t coef;
  logic  coef_ok;

  // front stage: angle difference, wrap and fold, voltage products
  logic                   s1_v_r;
  logic                   s1_rdy;
  logic signed [CS_W-1:0] s1_z_r;
  logic                   s1_neg_r;
  vpass_t                 s1_pass_r;

  logic signed [ANG_W:0]  d_raw, d_wrap, d_fold;
  logic                   d_neg;
  logic [SQP_W-1:0]       p_ii, p_ij, p_jj;
  vpass_t                 pass_nxt;

  logic                   cor_ready, cor_valid, cor_neg, pow_ready;
  logic signed [CS_W-1:0] cor_x, cor_y;
  vpass_t                 cor_pass;

  bpf_coef u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef),
    .coef_ok   (coef_ok)
  );

  // items are held off while the admittance terms are being rebuilt
  assign s1_rdy   = !s1_v_r || cor_ready;
  assign in_ready = s1_rdy && coef_ok;

  always_comb begin
    d_raw = $signed({in_from_angle[ANG_W-1], in_from_angle}) -
            $signed({in_to_angle[ANG_W-1], in_to_angle});
    // one turn is enough to bring any difference into (-180, 180]
    if (d_raw > ANG_HALF) begin
      d_wrap = d_raw - ANG_FULL;
    end else if (d_raw <= -ANG_HALF) begin
      d_wrap = d_raw + ANG_FULL;
    end else begin
      d_wrap = d_raw;
    end
    // fold into the right half plane, sign flipped at the end
    if (d_wrap > ANG_QUARTER) begin
      d_fold = d_wrap - ANG_HALF;
      d_neg  = 1'b1;
    end else if (d_wrap < -ANG_QUARTER) begin
      d_fold = d_wrap + ANG_HALF;
      d_neg  = 1'b1;
    end else begin
      d_fold = d_wrap;
      d_neg  = 1'b0;
    end
    p_ii = SQP_W'(in_from_voltage * in_from_voltage) + RND16;
    p_ij = SQP_W'(in_from_voltage * in_to_voltage) + RND16;
    p_jj = SQP_W'(in_to_voltage * in_to_voltage) + RND16;
    pass_nxt.vii = SQ_W'(p_ii >> 16);
    pass_nxt.vij = SQ_W'(p_ij >> 16);
    pass_nxt.vjj = SQ_W'(p_jj >> 16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_valid && coef_ok;
    end
  end

  // angle to Q8.24 for the cordic
  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_z_r    <= CS_W'(d_fold) <<< 8;
      s1_neg_r  <= d_neg;
      s1_pass_r <= pass_nxt;
    end
  end

  bpf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_v_r),
    .in_ready  (cor_ready),
    .in_z      (s1_z_r),
    .in_neg    (s1_neg_r),
    .in_pass   (s1_pass_r),
    .out_valid (cor_valid),
    .out_ready (pow_ready),
    .out_x     (cor_x),
    .out_y     (cor_y),
    .out_neg   (cor_neg),
    .out_pass  (cor_pass)
  );

  bpf_power u_power (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (cor_valid),
    .in_ready          (pow_ready),
    .in_x              (cor_x),
    .in_y              (cor_y),
    .in_neg            (cor_neg),
    .in_pass           (cor_pass),
    .coef              (coef),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_from_active   (out_from_active),
    .out_from_reactive (out_from_reactive),
    .out_to_active     (out_to_active),
    .out_to_reactive   (out_to_reactive),
    .out_active_loss   (out_active_loss),
    .out_reactive_loss (out_reactive_loss),
    .out_status        (out_status)
  );

endmodule

FILE: dv/branch_power_flow_test.sv
// self-checking testbench for the branch power flow pipeline
module branch_power_flow_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bpf_pkg::*;

  // cordic depth of the instance, also used by the flow predictor
  localparam int STEPS = CORDIC_STEPS_DEF;
  // pipeline depth from the header plus margin, used before register writes and at the end
  localparam int DRAIN_CYCLES = STEPS + 7 + 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PER_PHASE = 370;
  // a register index past the defined set, which the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
  localparam logic signed [127:0] SAT_HI = 128'sd2147483647;
  localparam logic signed [127:0] SAT_LO = -128'sd2147483648;

  typedef struct {
    logic [VOLT_W-1:0]        vf;
    logic [VOLT_W-1:0]        vt;
    logic signed [ANG_W-1:0]  af;
    logic signed [ANG_W-1:0]  at;
  } flow_item_t;

  // four end powers then the two losses
  typedef struct {
    logic signed [DATA_W-1:0] pw [6];
    status_t                  st;
  } flow_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // one line of the directed table; typed rows expect all powers zero and the given status
  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    data;
    flow_item_t           item;
    logic                 typed;
    status_t              st;
  } dir_row_t;

  localparam int DIR_ROWS = 24;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [VOLT_W-1:0] in_from_voltage;
  logic [VOLT_W-1:0] in_to_voltage;
  logic signed [ANG_W-1:0] in_from_angle;
  logic signed [ANG_W-1:0] in_to_angle;
  logic out_valid;
  logic out_ready;
  logic signed [DATA_W-1:0] out_from_active;
  logic signed [DATA_W-1:0] out_from_reactive;
  logic signed [DATA_W-1:0] out_to_active;
  logic signed [DATA_W-1:0] out_to_reactive;
  logic signed [DATA_W-1:0] out_active_loss;
  logic signed [DATA_W-1:0] out_reactive_loss;
  logic [STATUS_W-1:0] out_status;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  // local copy of the branch registers
  logic [DATA_W-1:0] res_reg;
  logic [DATA_W-1:0] reac_reg;
  logic [DATA_W-1:0] cond_reg;
  logic [DATA_W-1:0] susc_reg;
  logic [TAP_W-1:0]  tap_reg;

  flow_result_t pending_flows [$];
  int mismatches;
  int cycle_count;
  int idle_pct;
  int stall_pct;
  int hold_left;

  branch_power_flow #(.CORDIC_STEPS(STEPS)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_from_voltage   (in_from_voltage),
    .in_to_voltage     (in_to_voltage),
    .in_from_angle     (in_from_angle),
    .in_to_angle       (in_to_angle),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_from_active   (out_from_active),
    .out_from_reactive (out_from_reactive),
    .out_to_active     (out_to_active),
    .out_to_reactive   (out_to_reactive),
    .out_active_loss   (out_active_loss),
    .out_reactive_loss (out_reactive_loss),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // round half up of v / 2^k
  function automatic logic signed [127:0] round_shift(input logic signed [127:0] v, input int k);
    return (v + (128'sd1 <<< (k - 1))) >>> k;
  endfunction

  // a * 65536 / t, magnitude rounded half up, sign kept
  function automatic logic signed [127:0] tap_divide(input logic signed [127:0] a,
                                                     input logic signed [127:0] t);
    logic signed [127:0] mag;
    logic signed [127:0] q;
    mag = (a < 0) ? -a : a;
    q = ((mag <<< 16) + t / 2) / t;
    return (a < 0) ? -q : q;
  endfunction

  // num * 2^32 / z rounded, sign optionally flipped (series conductance and susceptance)
  function automatic logic signed [127:0] series_ratio(input logic signed [127:0] num,
                                                       input logic signed [127:0] z,
                                                       input logic flip);
    logic signed [127:0] mag;
    logic signed [127:0] q;
    mag = (num < 0) ? -num : num;
    q = ((mag <<< 32) + z / 2) / z;
    return ((num < 0) != flip) ? -q : q;
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp32(input logic signed [127:0] v,
                                                       inout logic sat);
    if (v > SAT_HI) begin
      sat = 1'b1;
      return SAT_HI[DATA_W-1:0];
    end
    if (v < SAT_LO) begin
      sat = 1'b1;
      return SAT_LO[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

  // cosine and sine of an angle in degrees (Q16.16), results in Q2.30
  task automatic angle_sincos(input longint d, output longint co, output longint si);
    longint xx;
    longint yy;
    longint zz;
    longint dx;
    longint dy;
    logic neg;
    neg = 1'b0;
    while (d > longint'(ANG_HALF)) d -= longint'(ANG_FULL);
    while (d <= -longint'(ANG_HALF)) d += longint'(ANG_FULL);
    // fold into the right half plane and negate afterwards
    if (d > longint'(ANG_QUARTER)) begin
      d -= longint'(ANG_HALF);
      neg = 1'b1;
    end else if (d < -longint'(ANG_QUARTER)) begin
      d += longint'(ANG_HALF);
      neg = 1'b1;
    end
    xx = longint'(CORDIC_START);
    yy = 0;
    zz = d * 256;
    for (int i = 0; i < STEPS && i < CORDIC_MAX; i++) begin
      dx = yy >>> i;
      dy = xx >>> i;
      if (zz >= 0) begin
        xx -= dx;
        yy += dy;
        zz -= longint'(ATAN_DEG[i]);
      end else begin
        xx += dx;
        yy -= dy;
        zz += longint'(ATAN_DEG[i]);
      end
    end
    co = neg ? -xx : xx;
    si = neg ? -yy : yy;
  endtask

  // expected end powers and losses for one item under the current registers
  task automatic predict_flow(input flow_item_t it, output flow_result_t res);
    logic signed [127:0] r, x, g, b, t, z;
    logic signed [127:0] gs, bs, gt, bt, y11r, y11i, y22r, y22i, y12r, y12i;
    logic signed [127:0] vi, vj, vii, vij, vjj, co, si, pc, ps, ip, iq, jp, jq;
    longint c64;
    longint s64;
    logic sat;
    r = 128'(signed'(res_reg));
    x = 128'(signed'(reac_reg));
    g = 128'(signed'(cond_reg));
    b = 128'(signed'(susc_reg));
    t = 128'(tap_reg);
    sat = 1'b0;
    if (t < 128'(TAP_MIN)) t = 128'(TAP_ONE);
    z = r * r + x * x;
    if (z == 0) begin
      foreach (res.pw[k]) res.pw[k] = '0;
      res.st = STAT_ZERO;
      return;
    end
    gs = series_ratio(r, z, 1'b0);
    bs = series_ratio(x, z, 1'b1);
    gt = tap_divide(g, t);
    bt = tap_divide(b, t);
    y12r = -tap_divide(gs, t);
    y12i = -tap_divide(bs, t);
    y11r = gs + gt;
    y11i = bs + bt;
    y22r = tap_divide(tap_divide(gs, t), t) + gt;
    y22i = tap_divide(tap_divide(bs, t), t) + bt;
    vi = 128'(it.vf);
    vj = 128'(it.vt);
    vii = round_shift(vi * vi, 16);
    vij = round_shift(vi * vj, 16);
    vjj = round_shift(vj * vj, 16);
    angle_sincos(longint'(it.af) - longint'(it.at), c64, s64);
    co = 128'(c64);
    si = 128'(s64);
    pc = round_shift(vij * co, 30);
    ps = round_shift(vij * si, 30);
    ip = round_shift(vii * y11r + pc * y12r + ps * y12i, 16);
    iq = round_shift(-vii * y11i + ps * y12r - pc * y12i, 16);
    jp = round_shift(vjj * y22r + pc * y12r - ps * y12i, 16);
    jq = round_shift(-vjj * y22i - ps * y12r - pc * y12i, 16);
    res.pw[0] = clamp32(ip, sat);
    res.pw[1] = clamp32(iq, sat);
    res.pw[2] = clamp32(jp, sat);
    res.pw[3] = clamp32(jq, sat);
    res.pw[4] = clamp32(ip + jp, sat);
    res.pw[5] = clamp32(iq + jq, sat);
    res.st = sat ? STAT_SAT : STAT_OK;
  endtask

  // offer one item after a random idle gap; the expectation is queued on the transfer
  task automatic send_item(input flow_item_t it, input logic typed, input status_t st);
    flow_result_t res;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_from_voltage = it.vf;
    in_to_voltage = it.vt;
    in_from_angle = it.af;
    in_to_angle = it.at;
    do @(posedge clk); while (!in_ready);
    if (typed) begin
      foreach (res.pw[k]) res.pw[k] = '0;
      res.st = st;
    end else begin
      predict_flow(it, res);
    end
    pending_flows.push_back(res);
  endtask

  // drop valid, then wait out every outstanding result and the pipeline tail
  task automatic drain_flows();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_flows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_R:   res_reg = val;
      REG_X:   reac_reg = val;
      REG_G:   cond_reg = val;
      REG_B:   susc_reg = val;
      REG_TAP: tap_reg = val[TAP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // realistic per-unit values half the time, full-range and extreme ones otherwise
  function automatic logic [DATA_W-1:0] rand_impedance();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return 32'h7fff_ffff;
      2:       return 32'h8000_0000;
      3:       return '0;
      4:       return 32'($urandom_range(3)) - 32'd1;
      default: return 32'($urandom_range(131072)) - 32'd65536;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_tap();
    case ($urandom_range(7))
      0:       return {1'b0, 31'($urandom)};
      1:       return 32'($urandom_range(6553));
      2:       return 32'h7fff_ffff;
      3:       return 32'd6554;
      default: return 32'($urandom_range(78643, 52429));
    endcase
  endfunction

  function automatic flow_item_t rand_item();
    flow_item_t it;
    if ($urandom_range(3) == 0) begin
      // any bit pattern, angles wrapped by the block
      it.vf = VOLT_W'($urandom);
      it.vt = VOLT_W'($urandom);
      it.af = ANG_W'($urandom);
      it.at = ANG_W'($urandom);
    end else begin
      // operating point near nominal voltage and moderate angle spread
      it.vf = VOLT_W'($urandom_range(72090, 58982));
      it.vt = VOLT_W'($urandom_range(72090, 58982));
      it.af = ANG_W'(signed'($urandom_range(3932160)) - 1966080);
      it.at = ANG_W'(signed'($urandom_range(3932160)) - 1966080);
    end
    return it;
  endfunction

  // directed table: extremes, angle wrap, small tap, zero impedance, saturation,
  // unknown register, every register written
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_ITEM, REG_R, 32'd0, '{18'd0, 18'd0, 25'sd0, 25'sd0}, 1'b1, STAT_OK},
    '{ROW_ITEM, REG_R, 32'd0, '{18'h3ffff, 18'h3ffff, 25'sd0, 25'sd0}, 1'b0, STAT_OK},
    '{ROW_ITEM, REG_R, 32'd0, '{18'd65536, 18'd65536, 25'sd5898240, -25'sd5898240},
      1'b0, STAT_OK},
    '{ROW_ITEM, REG_R, 32'd0, '{18'd65536, 18'd0, 25'sd11796480, -25'sd11796480},
      1'b0, STAT_OK},
    '{ROW_ITEM, REG_R, 32'd0, '{18'd1, 18'h3ffff, 25'sh0ff_ffff, 25'sh100_0000},
      1'b0, STAT_OK},
    '{ROW_ITEM, REG_R, 32'd0, '{18'h3ffff, 18'd1, 25'sh100_0000, 25'sh0ff_ffff},
      1'b0, STAT_OK},
    '{ROW_ITEM, REG_R, 32'd0, '{18'd65536, 18'd65536, 25'sd5898241, 25'sd0}, 1'b0, STAT_OK},
    '{ROW_CFG, REG_R, 32'd3277, '{18'd0, 18'd0, 25'sd0, 25'sd0}, 1'b0, STAT_OK},
    '{ROW_CFG, REG_G, 32'd1000, '{18'd0, 18'd0, 25'sd0, 25'sd0}, 1'b0, STAT_OK},
    '{ROW_CFG, REG_B, 32'd6554, '{18'd0, 18'd0, 25'sd0, 25'sd0}, 1'b0, STAT_OK},
    '{ROW_CFG, REG_TAP, 32'd6553, '{18'd0, 18'd0, 25'sd0, 25'sd0}, 1'b0, STAT_OK},
    '{ROW_ITEM, REG_R, 32'd0, '{18'd65536, 18'd62259, 25'sd655360, 25'sd0}, 1'b0, STAT_OK},
    '{ROW_CFG, REG_TAP, 32'h7fff_ffff, '{18'd0, 18'd0, 25'sd0, 25'sd0}, 1'b0, STAT_OK},
    '{ROW_ITEM, REG_R, 32'd0, '{18'd65536, 18'd62259, 25'sd655360, 25'sd0}, 1'b0, STAT_OK},
    '{ROW_CFG, REG_R, 32'd0, '{18'd0, 18'd0, 25'sd0, 25'sd0}, 1'b0, STAT_OK},
    '{ROW_CFG, REG_X, 32'd0, '{18'd0, 18'd0, 25'sd0, 25'sd0}, 1'b0, STAT_OK},
    '{ROW_ITEM, REG_R, 32'd0, '{18'h3ffff, 18'h3ffff, 25'sd100, 25'sd0}, 1'b1, STAT_ZERO},
    '{ROW_CFG, REG_R, 32'd1, '{18'd0, 18'd0, 25'sd0, 25'sd0}, 1'b0, STAT_OK},
    '{ROW_ITEM, REG_R, 32'd0, '{18'h3ffff, 18'd65536, 25'sd0, 25'sd0}, 1'b0, STAT_OK},
    '{ROW_CFG, REG_X, 32'h8000_0000, '{18'd0, 18'd0, 25'sd0, 25'sd0}, 1'b0, STAT_OK},
    '{ROW_CFG, REG_R, 32'h7fff_ffff, '{18'd0, 18'd0, 25'sd0, 25'sd0}, 1'b0, STAT_OK},
    '{ROW_CFG, REG_UNUSED, 32'hffff_ffff, '{18'd0, 18'd0, 25'sd0, 25'sd0}, 1'b0, STAT_OK},
    '{ROW_ITEM, REG_R, 32'd0, '{18'h3ffff, 18'h3ffff, 25'sd3000000, -25'sd3000000},
      1'b0, STAT_OK},
    '{ROW_CFG, REG_G, 32'h8000_0000, '{18'd0, 18'd0, 25'sd0, 25'sd0}, 1'b0, STAT_OK}
  };

  // receiver: random stalls at the phase rate, or a long hold-off when asked
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // result checker: every transfer on out is matched with the oldest expectation
  always @(posedge clk) begin
    flow_result_t want;
    logic signed [DATA_W-1:0] got [6];
    logic bad;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_from_active, out_from_reactive, out_to_active, out_to_reactive,
              out_active_loss, out_reactive_loss};
      if (pending_flows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at cycle %0d", cycle_count);
      end else begin
        want = pending_flows.pop_front();
        bad = (out_status != want.st);
        foreach (got[k]) if (got[k] !== want.pw[k]) bad = 1'b1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at cycle %0d", cycle_count);
            $display("  expected %0d %0d %0d %0d %0d %0d status %0d", want.pw[0], want.pw[1],
                     want.pw[2], want.pw[3], want.pw[4], want.pw[5], want.st);
            $display("  actual   %0d %0d %0d %0d %0d %0d status %0d", got[0], got[1],
                     got[2], got[3], got[4], got[5], out_status);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_from_voltage = '0;
    in_to_voltage = '0;
    in_from_angle = '0;
    in_to_angle = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    res_reg = R_RESET;
    reac_reg = X_RESET;
    cond_reg = G_RESET;
    susc_reg = B_RESET;
    tap_reg = TAP_RESET;
    mismatches = 0;
    cycle_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table, registers only rewritten once the pipeline is empty
    foreach (dir_rows[n]) begin
      if (dir_rows[n].kind == ROW_CFG) begin
        drain_flows();
        write_reg(dir_rows[n].idx, dir_rows[n].data);
      end else begin
        send_item(dir_rows[n].item, dir_rows[n].typed, dir_rows[n].st);
      end
    end

    // random phases: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      drain_flows();
      write_reg(REG_R, rand_impedance());
      write_reg(REG_X, rand_impedance());
      write_reg(REG_G, rand_impedance());
      write_reg(REG_B, rand_impedance());
      write_reg(REG_TAP, rand_tap());
      idle_pct = (ph == 1) ? 85 : (ph == 3) ? 26 : 0;
      stall_pct = (ph == 2) ? 85 : (ph == 3) ? 26 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // long receiver hold-off while items keep coming, so in_ready must drop
        if (ph == 0 && n == 100) hold_left = 300;
        // sender pause until every outstanding result has come back
        if (ph == 2 && n == 150) begin
          @(negedge clk);
          in_valid = 1'b0;
          while (pending_flows.size() != 0) @(posedge clk);
        end
        send_item(rand_item(), 1'b0, STAT_OK);
      end
    end

    drain_flows();
    if (mismatches == 0 && pending_flows.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: branch_power_flow.f
hw/rtl/bpf_pkg.sv
hw/rtl/bpf_div.sv
hw/rtl/bpf_coef.sv
hw/rtl/bpf_cordic.sv
hw/rtl/bpf_power.sv
hw/rtl/branch_power_flow.sv
dv/branch_power_flow_test.sv
